/* rtl/cramer_pkg.sv */
// Package for the 3x3 Cramer solver: widths, word types and pipeline records.
package cramer_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int FRAC_BITS  = 16;
  localparam int FIELD_W    = 16;
  localparam int SOL_W      = 64;
  localparam int PROD_W     = 2 * COEF_WIDTH;
  localparam int MINOR_W    = PROD_W + 1;
  localparam int TERM_W     = COEF_WIDTH + MINOR_W;
  localparam int DET_W      = 3 * COEF_WIDTH + 3;
  localparam int NUM_W      = DET_W + FRAC_BITS;
  localparam int CMP_W      = ((NUM_W > SOL_W) ? NUM_W : SOL_W) + 1;

  typedef struct packed {
    logic signed [FIELD_W-1:0] row1_coef_x;
    logic signed [FIELD_W-1:0] row1_coef_y;
    logic signed [FIELD_W-1:0] row1_coef_z;
    logic signed [FIELD_W-1:0] row1_rhs;
    logic signed [FIELD_W-1:0] row2_coef_x;
    logic signed [FIELD_W-1:0] row2_coef_y;
    logic signed [FIELD_W-1:0] row2_coef_z;
    logic signed [FIELD_W-1:0] row2_rhs;
    logic signed [FIELD_W-1:0] row3_coef_x;
    logic signed [FIELD_W-1:0] row3_coef_y;
    logic signed [FIELD_W-1:0] row3_coef_z;
    logic signed [FIELD_W-1:0] row3_rhs;
  } in_t;

  typedef struct packed {
    logic signed [SOL_W-1:0] sol_x;
    logic signed [SOL_W-1:0] sol_y;
    logic signed [SOL_W-1:0] sol_z;
    logic                    singular;
    logic                    overflowed;
  } out_t;

  typedef struct packed {
    logic [DET_W-1:0] rem;
    logic [NUM_W-1:0] num;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [2:0]  lane;
    logic [DET_W-1:0] dv;
    logic [2:0]       neg;
    logic             sing;
  } div_stage_t;

endpackage

/* rtl/cramer_3x3_solver.sv */
// Top level of the 3x3 Cramer solver: determinant pipeline and pipelined restoring dividers.
//
//   port group   dir   handshake            word
//   in_*         in    in_valid/in_ready    in_t, one 3x3 system
//   out_*        out   out_valid/out_ready  out_t, x, y, z and flags
//
// One word enters per cycle while the output is not stalled. The pipeline has 6 determinant stages,
// one restoring-division stage per quotient bit and one output register.
// The divider stages set the depth: three lanes share each stage.
// Reset (rst_n low, synchronous) clears all valid bits.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
module cramer_3x3_solver
  import cramer_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  typedef logic signed [COEF_WIDTH-1:0] coef_t;

  function automatic logic [DET_W-1:0] mag_of(input logic signed [DET_W-1:0] v);
    return v[DET_W-1] ? DET_W'(-v) : DET_W'(v);
  endfunction

  function automatic div_lane_t div_step(input div_lane_t l, input logic [DET_W-1:0] dv);
    div_lane_t        s;
    logic [DET_W:0]   t;
    logic             qb;
    t = {l.rem, l.num[NUM_W-1]};
    if (t >= {1'b0, dv}) begin
      t  = t - {1'b0, dv};
      qb = 1'b1;
    end else begin
      qb = 1'b0;
    end
    s.rem = t[DET_W-1:0];
    s.num = {l.num[NUM_W-2:0], qb};
    return s;
  endfunction

  logic en;
  logic [5:1] v_r;
  logic [NUM_W:0] dvv_r;

  coef_t                     co_r [12];
  coef_t                     r2_r [4];
  coef_t                     r3_r [4];
  coef_t                     r4_r [4];
  logic signed [PROD_W-1:0]  p_r  [12];
  logic signed [MINOR_W-1:0] mi_r [6];
  logic signed [TERM_W-1:0]  t_r  [12];
  logic signed [DET_W-1:0]   det_r [4];
  div_stage_t                ds_r [NUM_W+1];
  logic [DET_W-1:0]          dmag [4];

  out_t out_r, out_nxt;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      dvv_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[4:1], in_valid};
      dvv_r       <= {dvv_r[NUM_W-1:0], v_r[5]};
      out_valid_r <= dvv_r[NUM_W];
    end
  end

  // Stage 1: keep the low COEF_WIDTH bits of each field as a signed value.
  always_ff @(posedge clk) begin
    if (en) begin
      co_r[0]  <= coef_t'(in_data.row1_coef_x[COEF_WIDTH-1:0]);
      co_r[1]  <= coef_t'(in_data.row1_coef_y[COEF_WIDTH-1:0]);
      co_r[2]  <= coef_t'(in_data.row1_coef_z[COEF_WIDTH-1:0]);
      co_r[3]  <= coef_t'(in_data.row1_rhs[COEF_WIDTH-1:0]);
      co_r[4]  <= coef_t'(in_data.row2_coef_x[COEF_WIDTH-1:0]);
      co_r[5]  <= coef_t'(in_data.row2_coef_y[COEF_WIDTH-1:0]);
      co_r[6]  <= coef_t'(in_data.row2_coef_z[COEF_WIDTH-1:0]);
      co_r[7]  <= coef_t'(in_data.row2_rhs[COEF_WIDTH-1:0]);
      co_r[8]  <= coef_t'(in_data.row3_coef_x[COEF_WIDTH-1:0]);
      co_r[9]  <= coef_t'(in_data.row3_coef_y[COEF_WIDTH-1:0]);
      co_r[10] <= coef_t'(in_data.row3_coef_z[COEF_WIDTH-1:0]);
      co_r[11] <= coef_t'(in_data.row3_rhs[COEF_WIDTH-1:0]);
    end
  end

  // Stage 2: products of rows two and three for the six 2x2 minors.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]  <= co_r[5] * co_r[10];
      p_r[1]  <= co_r[9] * co_r[6];
      p_r[2]  <= co_r[4] * co_r[10];
      p_r[3]  <= co_r[6] * co_r[8];
      p_r[4]  <= co_r[4] * co_r[9];
      p_r[5]  <= co_r[5] * co_r[8];
      p_r[6]  <= co_r[7] * co_r[10];
      p_r[7]  <= co_r[6] * co_r[11];
      p_r[8]  <= co_r[7] * co_r[9];
      p_r[9]  <= co_r[5] * co_r[11];
      p_r[10] <= co_r[4] * co_r[11];
      p_r[11] <= co_r[7] * co_r[8];
      for (int i = 0; i < 4; i++) r2_r[i] <= co_r[i];
    end
  end

  // Stage 3: minors yz, xz, xy, rz, ry, xr (r is the right-hand side column).
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        mi_r[i] <= MINOR_W'(p_r[2*i]) - MINOR_W'(p_r[2*i+1]);
      end
      for (int i = 0; i < 4; i++) r3_r[i] <= r2_r[i];
    end
  end

  // Stage 4: first-row entries times minors, expanding along row one.
  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0]  <= r3_r[0] * mi_r[0];
      t_r[1]  <= r3_r[1] * mi_r[1];
      t_r[2]  <= r3_r[2] * mi_r[2];
      t_r[3]  <= r3_r[3] * mi_r[0];
      t_r[4]  <= r3_r[1] * mi_r[3];
      t_r[5]  <= r3_r[2] * mi_r[4];
      t_r[6]  <= r3_r[0] * mi_r[3];
      t_r[7]  <= r3_r[3] * mi_r[1];
      t_r[8]  <= r3_r[2] * mi_r[5];
      t_r[9]  <= r3_r[0] * mi_r[4];
      t_r[10] <= r3_r[1] * mi_r[5];
      t_r[11] <= r3_r[3] * mi_r[2];
      for (int i = 0; i < 4; i++) r4_r[i] <= r3_r[i];
    end
  end

  // Stage 5: the four determinants. The yr minor is the negated ry minor.
  always_ff @(posedge clk) begin
    if (en) begin
      det_r[0] <= DET_W'(t_r[0]) - DET_W'(t_r[1]) + DET_W'(t_r[2]);
      det_r[1] <= DET_W'(t_r[3]) - DET_W'(t_r[4]) + DET_W'(t_r[5]);
      det_r[2] <= DET_W'(t_r[6]) - DET_W'(t_r[7]) + DET_W'(t_r[8]);
      det_r[3] <= DET_W'(t_r[11]) - DET_W'(t_r[9]) - DET_W'(t_r[10]);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) dmag[i] = mag_of(det_r[i]);
  end

  // Stage 6: magnitudes, quotient signs and scaled numerators into the divider.
  always_ff @(posedge clk) begin
    if (en) begin
      ds_r[0].dv   <= dmag[0];
      ds_r[0].sing <= (det_r[0] == '0);
      for (int i = 0; i < 3; i++) begin
        ds_r[0].neg[i]      <= det_r[i+1][DET_W-1] ^ det_r[0][DET_W-1];
        ds_r[0].lane[i].rem <= '0;
        ds_r[0].lane[i].num <= NUM_W'(dmag[i+1]) << FRAC_BITS;
      end
    end
  end

  // One restoring-division step per stage, three lanes side by side.
  for (genvar s = 1; s <= NUM_W; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        ds_r[s].dv   <= ds_r[s-1].dv;
        ds_r[s].neg  <= ds_r[s-1].neg;
        ds_r[s].sing <= ds_r[s-1].sing;
        for (int i = 0; i < 3; i++) begin
          ds_r[s].lane[i] <= div_step(ds_r[s-1].lane[i], ds_r[s-1].dv);
        end
      end
    end
  end

  // Saturate each quotient to 64 bits and apply its sign; a singular system yields all zeros.
  always_comb begin
    logic [CMP_W-1:0]       qe;
    logic [CMP_W-1:0]       lim;
    logic [2:0]             ovf;
    logic [2:0][SOL_W-1:0]  sol;
    for (int i = 0; i < 3; i++) begin
      qe  = CMP_W'(ds_r[NUM_W].lane[i].num);
      lim = ds_r[NUM_W].neg[i] ? (CMP_W'(1) << (SOL_W-1))
                               : ((CMP_W'(1) << (SOL_W-1)) - CMP_W'(1));
      ovf[i] = (qe > lim);
      if (ovf[i]) qe = lim;
      sol[i] = ds_r[NUM_W].neg[i] ? SOL_W'(-qe) : SOL_W'(qe);
    end
    if (ds_r[NUM_W].sing) begin
      out_nxt = '0;
      out_nxt.singular = 1'b1;
    end else begin
      out_nxt.sol_x      = sol[0];
      out_nxt.sol_y      = sol[1];
      out_nxt.sol_z      = sol[2];
      out_nxt.singular   = 1'b0;
      out_nxt.overflowed = |ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/cramer_checker.sv */
// Port-level checker for the 3x3 Cramer solver and its bind.
module cramer_checker
  import cramer_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input word dropped before acceptance");

  a_singular: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |->
      out_data.sol_x == '0 && out_data.sol_y == '0 && out_data.sol_z == '0
      && !out_data.overflowed)
    else $error("singular word carries nonzero solution");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready disagrees with output stall");

endmodule

bind cramer_3x3_solver cramer_checker u_cramer_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
